// ----- src/rgbled_pkg.sv -----
package rgbled_pkg;

   // Color word: green in the top byte, blue in the bottom byte
   localparam int ColorW = 24;
   localparam int BitsPerPixel = 24;
   localparam int BitIdxW = $clog2(BitsPerPixel + 1);

   localparam int ZeroHighW = 12;
   localparam int OneHighW = 12;
   localparam int PeriodW = 13;
   localparam int GapW = 20;
   localparam int CountW = 20;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW = 20;

   localparam logic [ZeroHighW-1:0] ZeroHighReset = 12'd35;
   localparam logic [OneHighW-1:0] OneHighReset = 12'd70;
   localparam logic [PeriodW-1:0] PeriodReset = 13'd125;
   localparam logic [GapW-1:0] GapReset = 20'd8000;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_LATCH = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_PIXEL,
      KIND_LATCH
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_BITS  = 2'd1,
      PH_LATCH = 2'd2
   } phase_type;

   typedef enum logic [CsrIndexW-1:0] {
      REG_ZERO_HIGH = 2'd0,
      REG_ONE_HIGH  = 2'd1,
      REG_PERIOD    = 2'd2,
      REG_GAP       = 2'd3
   } reg_index_type;

   // One classified request as it travels through the queue
   typedef struct packed {
      kind_type            kind;
      logic [ColorW-1:0]   pixel;
      logic                last;
   } entry_type;

endpackage

// ----- src/rgbled_front.sv -----
module rgbled_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   output logic                  push_valid,
   input  logic                  push_ready,
   output rgbled_pkg::entry_type push_entry
);
   import rgbled_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   kind_type  kind;

   always_comb begin
      unique case (req_tuser)
         CMD_PIXEL: kind = KIND_PIXEL;
         CMD_LATCH: kind = KIND_LATCH;
         default:   kind = KIND_TICK;
      endcase
   end

   assign req_tready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (push_ready) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         entry_in.kind = kind;
         // reorder to green:red:blue, green on top
         entry_in.pixel = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
         entry_in.last = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ----- src/rgbled_queue.sv -----
module rgbled_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  rgbled_pkg::entry_type push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output rgbled_pkg::entry_type pop_entry
);
   import rgbled_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/rgbled_engine.sv -----
module rgbled_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rgbled_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [rgbled_pkg::CsrDataW-1:0]     csr_data,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  rgbled_pkg::entry_type               pop_entry,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,
   output logic                                rsp_tlast
);
   import rgbled_pkg::*;

   localparam logic [BitIdxW-1:0] BitsLimit = BitIdxW'(BitsPerPixel);

   logic [ZeroHighW-1:0] zero_high_ff;
   logic [OneHighW-1:0]  one_high_ff;
   logic [PeriodW-1:0]   period_ff;
   logic [GapW-1:0]      gap_ff;

   phase_type            phase_ff, phase_in;
   logic [ColorW-1:0]    shift_ff, shift_in;
   logic [BitIdxW-1:0]   bit_idx_ff, bit_idx_in;
   logic [CountW-1:0]    count_ff, count_in;
   logic [ColorW-1:0]    held_pix_ff, held_pix_in;
   logic                 held_valid_ff, held_valid_in;
   logic                 held_last_ff, held_last_in;
   logic                 cur_last_ff, cur_last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3:0]           rsp_bits_ff, rsp_bits_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 pop;
   logic                 level, taken, busy, done, under;
   logic [PeriodW-1:0]   period;
   logic [PeriodW-1:0]   high;
   logic [GapW-1:0]      gap;
   logic [CountW-1:0]    count_next;

   assign csr_ready = 1'b1;
   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign pop = pop_valid && pop_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'd0, rsp_bits_ff};
   assign rsp_tlast = rsp_done_ff;

   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      bit_idx_in = bit_idx_ff;
      count_in = count_ff;
      held_pix_in = held_pix_ff;
      held_valid_in = held_valid_ff;
      held_last_in = held_last_ff;
      cur_last_in = cur_last_ff;
      level = 1'b0;
      taken = 1'b0;
      busy = 1'b0;
      done = 1'b0;
      under = 1'b0;
      period = (period_ff < 13'd2) ? 13'd2 : period_ff;
      high = '0;
      gap = (gap_ff == '0) ? 20'd1 : gap_ff;
      count_next = '0;

      if (pop) begin
         if (pop_entry.kind == KIND_PIXEL && !held_valid_in) begin
            held_pix_in = pop_entry.pixel;
            held_last_in = pop_entry.last;
            held_valid_in = 1'b1;
            taken = 1'b1;
         end else if (pop_entry.kind == KIND_LATCH && phase_in == PH_IDLE &&
                      !held_valid_in) begin
            phase_in = PH_LATCH;
            count_in = '0;
            taken = 1'b1;
         end

         // start the held pixel when the line is free
         if (phase_in == PH_IDLE && held_valid_in) begin
            shift_in = held_pix_in;
            cur_last_in = held_last_in;
            held_valid_in = 1'b0;
            bit_idx_in = '0;
            count_in = '0;
            phase_in = PH_BITS;
         end

         unique case (phase_in)
            PH_BITS: begin
               high = shift_in[ColorW-1] ? {1'b0, one_high_ff} : {1'b0, zero_high_ff};
               if (high > period - 13'd1) begin
                  high = period - 13'd1;
               end
               level = (count_in < {7'd0, high});
               busy = 1'b1;
               count_next = count_in + 20'd1;
               count_in = count_next;
               if (count_next >= {7'd0, period}) begin
                  count_in = '0;
                  shift_in = {shift_in[ColorW-2:0], 1'b0};
                  bit_idx_in = bit_idx_in + BitIdxW'(1);
                  if (bit_idx_in >= BitsLimit) begin
                     if (cur_last_in) begin
                        phase_in = PH_LATCH;
                        bit_idx_in = '0;
                     end else if (held_valid_in) begin
                        shift_in = held_pix_in;
                        cur_last_in = held_last_in;
                        held_valid_in = 1'b0;
                        bit_idx_in = '0;
                        count_in = '0;
                     end else begin
                        under = 1'b1;
                        phase_in = PH_IDLE;
                        bit_idx_in = '0;
                     end
                  end
               end
            end
            PH_LATCH: begin
               busy = 1'b1;
               count_next = count_in + 20'd1;
               count_in = count_next;
               if (count_next >= gap) begin
                  done = 1'b1;
                  phase_in = PH_IDLE;
                  count_in = '0;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_bits_in = rsp_bits_ff;
      rsp_done_in = rsp_done_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_bits_in = {under, busy, taken, level};
         rsp_done_in = done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff <= ZeroHighReset;
         one_high_ff <= OneHighReset;
         period_ff <= PeriodReset;
         gap_ff <= GapReset;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_ZERO_HIGH: zero_high_ff <= csr_data[ZeroHighW-1:0];
            REG_ONE_HIGH:  one_high_ff <= csr_data[OneHighW-1:0];
            REG_PERIOD:    period_ff <= csr_data[PeriodW-1:0];
            REG_GAP:       gap_ff <= csr_data[GapW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         bit_idx_ff <= '0;
         count_ff <= '0;
         held_pix_ff <= '0;
         held_valid_ff <= 1'b0;
         held_last_ff <= 1'b0;
         cur_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bit_idx_ff <= bit_idx_in;
         count_ff <= count_in;
         held_pix_ff <= held_pix_in;
         held_valid_ff <= held_valid_in;
         held_last_ff <= held_last_in;
         cur_last_ff <= cur_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_bits_ff <= rsp_bits_in;
      rsp_done_ff <= rsp_done_in;
   end

endmodule

// ----- src/rgb_led_one_wire_encoder.sv -----
// One-wire encoder for addressable RGB LEDs. Every request is one tick of the
// line waveform and yields exactly one response carrying the line level for
// that tick plus status flags. A tick may offer a pixel (green, red, blue,
// last flag) into a one-pixel holding register; pixels go out green first,
// MSB first, each bit high for the zero or one high time (clamped to one less
// than the bit period) and low for the rest of the period. After a pixel
// flagged last, or on a reset-only request, the line stays low for the latch
// gap and frame_done (rsp_tlast) marks its final tick. A request is taken while
// the response side keeps up: the front stage classifies it, a two-entry queue
// decouples it, and the waveform engine advances its bit and gap counters one
// tick per request, so the sustained rate is one request per clock while
// rsp_tready stays high. Write the timing registers only while no requests are
// in flight.
module rgb_led_one_wire_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // green, red, blue
   input  logic [1:0]                       req_tuser,  // cmd
   input  logic                             req_tlast,  // last_pixel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // line_level, pixel_taken, busy_res, underrun, zero padding
   output logic [7:0]                       rsp_tdata,
   output logic                             rsp_tlast,  // frame_done
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rgbled_pkg::CsrIndexW-1:0] csr_index,
   input  logic [rgbled_pkg::CsrDataW-1:0]  csr_data
);
   import rgbled_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   rgbled_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rgbled_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rgbled_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/rgb_led_one_wire_encoder_tb.sv -----
module rgb_led_one_wire_encoder_tb;
   import rgbled_pkg::*;

   localparam int Limit = 1_000_000;
   localparam int LongHold = 250;
   localparam logic [1:0] CmdUnknown = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic       last_px;
   } led_req_type;

   typedef struct packed {
      logic level;
      logic taken;
      logic busy;
      logic done;
      logic under;
   } tick_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;
   logic [1:0]           req_tuser = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_data = '0;

   rgb_led_one_wire_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Timing registers as the encoder should hold them
   logic [ZeroHighW-1:0] c_zero = ZeroHighReset;
   logic [OneHighW-1:0]  c_one = OneHighReset;
   logic [PeriodW-1:0]   c_period = PeriodReset;
   logic [GapW-1:0]      c_gap = GapReset;

   // Waveform state of the encoder
   logic [ColorW-1:0]  p_shift = '0;
   logic [BitIdxW-1:0] p_bit = '0;
   logic [CountW-1:0]  p_count = '0;
   logic [ColorW-1:0]  p_held = '0;
   logic               p_held_v = 1'b0;
   logic               p_held_last = 1'b0;
   logic               p_cur_last = 1'b0;
   phase_type          p_phase = PH_IDLE;

   led_req_type     pending_reqs[$];
   tick_result_type expected_ticks[$];

   int  req_offered = 0;
   int  req_accepted = 0;
   int  rsp_seen = 0;
   int  mismatches = 0;
   int  cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  hold_req = 0;
   int  hold_ack = 0;
   bit  sender_paused = 1'b0;
   bit  no_idle = 1'b0;
   led_req_type drv_item;

   function automatic void start_held_pixel();
      p_shift = p_held;
      p_cur_last = p_held_last;
      p_held_v = 1'b0;
      p_bit = '0;
      p_count = '0;
      p_phase = PH_BITS;
   endfunction

   function automatic tick_result_type predict_tick(logic [1:0] cmd, logic [7:0] green,
                                                    logic [7:0] red, logic [7:0] blue,
                                                    logic last_px);
      tick_result_type res;
      int unsigned     period;
      int unsigned     high;
      int unsigned     gap;
      res = '0;
      if (cmd == CMD_PIXEL && !p_held_v) begin
         p_held = {green, red, blue};
         p_held_last = last_px;
         p_held_v = 1'b1;
         res.taken = 1'b1;
      end else if (cmd == CMD_LATCH && p_phase == PH_IDLE && !p_held_v) begin
         p_phase = PH_LATCH;
         p_count = '0;
         res.taken = 1'b1;
      end
      if (p_phase == PH_IDLE && p_held_v)
         start_held_pixel();
      if (p_phase == PH_BITS) begin
         period = (c_period < 2) ? 2 : c_period;
         high = p_shift[ColorW-1] ? c_one : c_zero;
         if (high > period - 1)
            high = period - 1;
         res.level = (p_count < high);
         res.busy = 1'b1;
         p_count = p_count + 1'b1;
         if (p_count >= period) begin
            p_count = '0;
            p_shift = p_shift << 1;
            p_bit = p_bit + 1'b1;
            if (p_bit >= BitsPerPixel) begin
               if (p_cur_last) begin
                  p_phase = PH_LATCH;
                  p_bit = '0;
               end else if (p_held_v) begin
                  start_held_pixel();
               end else begin
                  res.under = 1'b1;
                  p_phase = PH_IDLE;
                  p_bit = '0;
               end
            end
         end
      end else if (p_phase == PH_LATCH) begin
         gap = (c_gap == 0) ? 1 : c_gap;
         res.busy = 1'b1;
         p_count = p_count + 1'b1;
         if (p_count >= gap) begin
            res.done = 1'b1;
            p_phase = PH_IDLE;
            p_count = '0;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch on response %0d: %s got %0d want %0d", rsp_seen, what, got, want);
   endtask

   // Predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_ticks.push_back(predict_tick(req_tuser, req_tdata[7:0], req_tdata[15:8],
                                                  req_tdata[23:16], req_tlast));
            req_accepted <= req_accepted + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_ticks.size() == 0) begin
               report_mismatch("response with nothing expected", 1, 0);
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_tdata[0] !== want.level)
                  report_mismatch("line_level", rsp_tdata[0], want.level);
               if (rsp_tdata[1] !== want.taken)
                  report_mismatch("pixel_taken", rsp_tdata[1], want.taken);
               if (rsp_tdata[2] !== want.busy)
                  report_mismatch("busy_res", rsp_tdata[2], want.busy);
               if (rsp_tdata[3] !== want.under)
                  report_mismatch("underrun", rsp_tdata[3], want.under);
               if (rsp_tdata[7:4] !== 4'd0)
                  report_mismatch("padding", rsp_tdata[7:4], 0);
               if (rsp_tlast !== want.done)
                  report_mismatch("frame_done", rsp_tlast, want.done);
            end
            rsp_seen++;
         end
      end
   end

   // Request driver: hold an offered request until taken, idle in random bursts
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_accepted != req_offered) begin
         // hold
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (sender_paused || pending_reqs.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 6) begin
         send_gap = $urandom_range(1, 19) - 1;
         req_tvalid <= 1'b0;
      end else begin
         drv_item = pending_reqs.pop_front();
         req_tdata <= {drv_item.blue, drv_item.red, drv_item.green};
         req_tuser <= drv_item.cmd;
         req_tlast <= drv_item.last_px;
         req_offered++;
         req_tvalid <= 1'b1;
      end
   end

   // Response sink: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_ack != hold_req) begin
         hold_ack = hold_req;
         hold_left = LongHold;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 6) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > Limit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void push_req(logic [1:0] cmd, logic [7:0] green, logic [7:0] red,
                                    logic [7:0] blue, logic last_px);
      led_req_type item;
      item.cmd = cmd;
      item.green = green;
      item.red = red;
      item.blue = blue;
      item.last_px = last_px;
      pending_reqs.push_back(item);
   endfunction

   function automatic void push_ticks(int n);
      for (int i = 0; i < n; i++)
         push_req(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom_range(0, 1)));
   endfunction

   function automatic void push_random(int n, int pixel_pct);
      int         roll;
      logic [1:0] cmd;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < pixel_pct)
            cmd = CMD_PIXEL;
         else if (roll < pixel_pct + 5)
            cmd = CMD_LATCH;
         else if (roll < pixel_pct + 8)
            cmd = CmdUnknown;
         else
            cmd = CMD_TICK;
         push_req(cmd, 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(0, 3) == 0);
      end
   endfunction

   // Wait until every request is taken and answered, then let the pipeline settle
   task automatic drain();
      while (!(pending_reqs.size() == 0 && req_accepted == req_offered &&
               expected_ticks.size() == 0))
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         REG_ZERO_HIGH: c_zero = value[ZeroHighW-1:0];
         REG_ONE_HIGH:  c_one = value[OneHighW-1:0];
         REG_PERIOD:    c_period = value[PeriodW-1:0];
         REG_GAP:       c_gap = value[GapW-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(int zero_hi, int one_hi, int period, int gap);
      write_reg(REG_ZERO_HIGH, CsrDataW'(zero_hi));
      write_reg(REG_ONE_HIGH, CsrDataW'(one_hi));
      write_reg(REG_PERIOD, CsrDataW'(period));
      write_reg(REG_GAP, CsrDataW'(gap));
   endtask

   function automatic int rand_high(int period);
      if ($urandom_range(0, 7) == 0)
         return 4095;
      return $urandom_range(0, period + 1);
   endfunction

   initial begin
      int period;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing: a few bits of one pixel at the default period
      push_req(CMD_PIXEL, 8'hA5, 8'h3C, 8'hF0, 1'b0);
      push_ticks(300);
      drain();
      // Period lowered mid-bit: the bit ends on the next tick
      set_timing(1, 1, 2, 2);
      push_ticks(60);
      drain();

      // Back-to-back pixels, offers while full, ignored reset request, unknown command
      push_req(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0);
      push_req(CMD_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b1);
      push_req(CMD_PIXEL, 8'h55, 8'hAA, 8'h55, 1'b1);
      push_req(CMD_LATCH, 8'h00, 8'h00, 8'h00, 1'b0);
      push_req(CmdUnknown, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_ticks(110);
      // Reset-only frame end while idle
      push_req(CMD_LATCH, 8'h00, 8'h00, 8'h00, 1'b0);
      push_ticks(4);
      // Lone non-last pixel runs dry, then a later pixel restarts the stream
      push_req(CMD_PIXEL, 8'h81, 8'h7E, 8'h01, 1'b0);
      push_ticks(60);
      push_req(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_ticks(60);
      drain();

      // Widest timing values
      set_timing(4095, 4095, 4096, 2);
      push_req(CMD_PIXEL, 8'h80, 8'h00, 8'h01, 1'b0);
      push_ticks(40);
      drain();
      write_reg(REG_PERIOD, CsrDataW'(13'h1FFF));
      push_ticks(10);
      drain();
      write_reg(REG_PERIOD, CsrDataW'(2));
      push_ticks(60);
      drain();
      write_reg(REG_GAP, CsrDataW'(20'hFFFFF));
      push_req(CMD_LATCH, 8'h00, 8'h00, 8'h00, 1'b0);
      push_ticks(20);
      drain();
      // Zero gap acts as one: the running gap closes on the next tick
      write_reg(REG_GAP, CsrDataW'(0));
      push_ticks(3);
      drain();

      // Shortest timing
      set_timing(1, 1, 2, 1);
      push_random(185, 45);
      drain();

      // Zero-bit high time zero, one-bit clamped; sender pauses midway
      set_timing(0, 4095, 3, 0);
      push_random(185, 45);
      while (pending_reqs.size() > 90)
         @(posedge clock);
      sender_paused = 1'b1;
      while (!(req_accepted == req_offered && expected_ticks.size() == 0))
         @(posedge clock);
      sender_paused = 1'b0;
      drain();

      // Period zero acts as two; sparse pixels give underruns; long receiver hold
      set_timing(4095, 0, 0, 7);
      push_random(185, 5);
      repeat (20) @(posedge clock);
      hold_req++;
      drain();

      period = $urandom_range(2, 6);
      set_timing(rand_high(period), rand_high(period), period, $urandom_range(1, 30));
      push_random(185, 30);
      drain();

      set_timing(2, 1, 1, 3);
      push_random(185, 60);
      drain();

      // Full rate on both sides
      no_idle = 1'b1;
      period = $urandom_range(2, 6);
      set_timing(rand_high(period), rand_high(period), period, $urandom_range(1, 30));
      push_random(185, 40);
      drain();

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
